// File: hw/rtl/mt19937_uniform_bernoulli_sampler_core_macros.svh
// assertion macros used by the sampler back end
`ifndef MT19937_UNIFORM_BERNOULLI_SAMPLER_CORE_MACROS_SVH
`define MT19937_UNIFORM_BERNOULLI_SAMPLER_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define MT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define MT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/mtubs_pkg.sv
// shared types and constants for the mt19937 sampler
package mtubs_pkg;

  localparam int unsigned MtN = 624;
  localparam int unsigned MtM = 397;
  localparam int unsigned IdxW = 10;
  localparam logic [31:0] MatrixA = 32'h9908B0DF;
  localparam logic [31:0] InitMult = 32'd1812433253;
  localparam logic [31:0] FpOneBits = 32'h3F800000;

  localparam logic [1:0] ReqUniform = 2'd0;
  localparam logic [1:0] ReqBern24 = 2'd1;
  localparam logic [1:0] ReqBern53 = 2'd2;
  localparam logic [1:0] ReqUnused = 2'd3;

  localparam logic CfgSeed = 1'b0;
  localparam logic CfgReseed = 1'b1;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] prob;
    logic        seed;   // reseed before drawing
  } cmd_t;

  // mt tempering
  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9D2C5680);
    y = y ^ ((y << 15) & 32'hEFC60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: hw/rtl/mt19937_uniform_bernoulli_sampler_core.sv
// top level of the mt19937 uniform and bernoulli sampler
//  channel | signals                                      | dir
//  input   | in_valid/in_ready, req_type, prob, start     | in
//  output  | out_valid/out_ready, value_bits              | out
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i              | in
// the back takes an item and steps through read, draw and compare to a registered result (twice for two draws)
// a waiting result holds the back, so it takes no new item until the last result is taken
// seeding sweeps the 624-word memory with a multiply, then an add and write, per word
// a twist regenerates all 624 words, reading words i+1 and i+m and writing word i, once per 624 draws
// the front queue holds two items so input keeps flowing while the back works
module mt19937_uniform_bernoulli_sampler_core
  import mtubs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] prob_bits_i,
  input  logic        call_start_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value_bits_o
);

  logic [31:0] seed_q;
  logic        reseed_q;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      reseed_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSeed:   seed_q <= cfg_data_i;
        CfgReseed: reseed_q <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  mtubs_front u_front (
    .clk_i, .rst_ni,
    .reseed_each_call_i(reseed_q),
    .in_valid, .in_ready,
    .req_type_i, .prob_bits_i, .call_start_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  mtubs_back u_back (
    .clk_i, .rst_ni,
    .seed_value_i(seed_q),
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid, .out_ready, .value_bits_o
  );

endmodule

// File: hw/rtl/mtubs_front.sv
// front end: accepts items, decides reseeding, feeds a two-entry queue
module mtubs_front
  import mtubs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        reseed_each_call_i,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] prob_bits_i,
  input  logic        call_start_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       seeded_q;
  logic       push, pop;

  assign in_ready    = (cnt_q != 2'd2);
  assign push        = in_valid && in_ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rd_q];

  assign wr_d  = push ? ~wr_q : wr_q;
  assign rd_d  = pop ? ~rd_q : rd_q;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  // queue pointers and seeded flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
      seeded_q <= 1'b0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
      if (push) seeded_q <= 1'b1;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q].req  <= req_type_i;
      mem_q[wr_q].prob <= prob_bits_i;
      mem_q[wr_q].seed <= !seeded_q || (reseed_each_call_i && call_start_i);
    end
  end

endmodule

// File: hw/rtl/mtubs_back.sv
// back end: twister memory, seeding sweep, draws and threshold compare
module mtubs_back
  import mtubs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] seed_value_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value_bits_o
);

  `include "mt19937_uniform_bernoulli_sampler_core_macros.svh"

  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StSeed  = 8'b00000010,
    StTwA   = 8'b00000100,
    StTwB   = 8'b00001000,
    StRead  = 8'b00010000,
    StDraw  = 8'b00100000,
    StCmp   = 8'b01000000,
    StOut   = 8'b10000000
  } state_e;

  state_e          st_q, st_d;
  logic [31:0]     mem [MtN];
  logic [IdxW-1:0] idx_q, idx_d;       // next word to draw, MtN means twist
  logic [IdxW-1:0] ptr_q, ptr_d;       // sweep pointer
  logic [31:0]     prev_q, prev_d;     // last seeded word
  logic [31:0]     mul_q, mul_d;       // seed multiplier result
  logic            mphase_q, mphase_d;
  logic [31:0]     w0_q;               // word i during twist
  logic [31:0]     yreg_q;             // combined upper/lower word during twist
  logic [31:0]     rd_q;               // registered memory read
  logic [31:0]     hi_q, hi_d;
  logic            second_q, second_d;
  cmd_t            cmd_q;
  logic            take;
  logic [31:0]     draw;
  logic [52:0]     x53;
  logic [31:0]     res_q, res_d;
  logic            ovalid_q, ovalid_d;
  // memory port control
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [31:0]     wdata;
  logic [IdxW-1:0] ip1, im;
  logic [31:0]     y, v;

  assign take = (st_q == StIdle) && cmd_valid_i && !ovalid_q;
  assign cmd_ready_o = take;
  assign out_valid = ovalid_q;
  assign value_bits_o = res_q;
  assign draw = temper(rd_q);
  assign x53 = {hi_q[20:0], draw};

  assign ip1 = (ptr_q == IdxW'(MtN - 1)) ? '0 : ptr_q + 1'b1;
  assign im  = (ptr_q >= IdxW'(MtN - MtM)) ? ptr_q - IdxW'(MtN - MtM)
                                           : ptr_q + IdxW'(MtM);
  assign y = {w0_q[31], rd_q[30:0]};

  // exact test x * 2^-n < p
  function automatic logic below(input logic [52:0] x, input logic is53,
                                 input logic [31:0] p);
    logic [7:0]  e;
    logic [23:0] mant;
    int          s;
    logic [52:0] xs;
    below = 1'b0;
    e = p[30:23];
    mant = (e == 8'd0) ? {1'b0, p[22:0]} : {1'b1, p[22:0]};
    s = (e == 8'd0) ? -149 : (int'(e) - 150);
    s = s + (is53 ? 53 : 24);
    xs = '0;
    if (p[31]) below = 1'b0;
    else if (e == 8'hFF) below = (p[22:0] == 23'd0);
    else if (mant == 24'd0) below = 1'b0;
    else if (s >= 0) begin
      if (s >= 63) below = 1'b1;
      else begin
        xs = x >> s;
        below = xs < 53'(mant);
      end
    end else if (x == 53'd0) below = 1'b1;
    else if (-s >= 24 || x >= 53'h1000000) below = 1'b0;
    else begin
      xs = x << (-s);
      below = xs < 53'(mant);
    end
  endfunction

  // float encoding of a 24-bit value times 2^-24
  function automatic logic [31:0] enc24(input logic [23:0] x);
    logic [4:0]  m;
    logic [23:0] sh;
    m = 5'd0;
    for (int i = 0; i < 24; i++) if (x[i]) m = 5'(i);
    sh = x << (5'd23 - m);
    enc24 = (x == 24'd0) ? 32'd0 : {1'b0, 8'(8'd103 + {3'd0, m}), sh[22:0]};
  endfunction

  // twist combine of word i (w0) with i+1 (y) and i+m (r)
  function automatic logic [31:0] mem_rd_twist(input logic [31:0] r,
                                               input logic [31:0] yy);
    mem_rd_twist = r ^ (yy >> 1) ^ (yy[0] ? MatrixA : 32'd0);
  endfunction

  // state sequencing
  always_comb begin
    st_d = st_q;
    idx_d = idx_q;
    ptr_d = ptr_q;
    prev_d = prev_q;
    mul_d = mul_q;
    mphase_d = mphase_q;
    hi_d = hi_q;
    second_d = second_q;
    res_d = res_q;
    ovalid_d = ovalid_q;
    we = 1'b0;
    waddr = ptr_q;
    wdata = '0;
    raddr = idx_q;
    v = mem_rd_twist(rd_q, yreg_q);
    if (ovalid_q && out_ready) ovalid_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (take) begin
          second_d = 1'b0;
          if (cmd_i.seed) begin
            we = 1'b1;
            waddr = '0;
            wdata = seed_value_i;
            prev_d = seed_value_i;
            ptr_d = IdxW'(1);
            mphase_d = 1'b0;
            st_d = StSeed;
          end else if (cmd_i.req == ReqUnused) begin
            res_d = '0;
            ovalid_d = 1'b1;
          end else st_d = StRead;
        end
      end
      StSeed: begin
        // per word: multiply, then add and write
        if (!mphase_q) begin
          mul_d = InitMult * (prev_q ^ (prev_q >> 30));
          mphase_d = 1'b1;
        end else begin
          we = 1'b1;
          wdata = mul_q + 32'(ptr_q);
          prev_d = wdata;
          mphase_d = 1'b0;
          if (ptr_q == IdxW'(MtN - 1)) begin
            idx_d = IdxW'(MtN);
            if (cmd_q.req == ReqUnused) begin
              res_d = '0;
              ovalid_d = 1'b1;
              st_d = StIdle;
            end else st_d = StRead;
          end else ptr_d = ptr_q + 1'b1;
        end
      end
      StRead: begin
        if (idx_q == IdxW'(MtN)) begin
          ptr_d = '0;
          raddr = '0;
          st_d = StTwA;
        end else begin
          raddr = idx_q;
          st_d = StDraw;
        end
      end
      StTwA: begin
        // rd_q holds word i, captured into w0_q; fetch word i+1
        raddr = ip1;
        st_d = StTwB;
      end
      StTwB: begin
        // y available; fetch word i+m next, then write
        raddr = im;
        mphase_d = ~mphase_q;
        if (mphase_q) begin
          we = 1'b1;
          wdata = v;
          mphase_d = 1'b0;
          if (ptr_q == IdxW'(MtN - 1)) begin
            idx_d = '0;
            st_d = StRead;
          end else begin
            ptr_d = ptr_q + 1'b1;
            raddr = ip1;
            st_d = StTwA;
          end
        end
      end
      StDraw: begin
        // keep reading the drawn word, then advance
        idx_d = idx_q + 1'b1;
        st_d = StCmp;
      end
      StCmp: begin
        if (cmd_q.req == ReqBern53 && !second_q) begin
          hi_d = draw;
          second_d = 1'b1;
          st_d = StRead;
        end else begin
          unique case (cmd_q.req)
            ReqUniform: res_d = enc24(draw[23:0]);
            ReqBern24:  res_d = below({29'd0, draw[23:0]}, 1'b0, cmd_q.prob)
                                ? FpOneBits : 32'd0;
            default:    res_d = below(x53, 1'b1, cmd_q.prob) ? FpOneBits : 32'd0;
          endcase
          ovalid_d = 1'b1;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  // memory with one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // twist operand and command capture
  always_ff @(posedge clk_i) begin
    if (st_q == StTwA) w0_q <= rd_q;
    if (st_q == StTwB && !mphase_q) yreg_q <= y;
    if (take) cmd_q <= cmd_i;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      idx_q <= IdxW'(MtN);
      ovalid_q <= 1'b0;
      mphase_q <= 1'b0;
      second_q <= 1'b0;
      ptr_q <= '0;
    end else begin
      st_q <= st_d;
      idx_q <= idx_d;
      ovalid_q <= ovalid_d;
      mphase_q <= mphase_d;
      second_q <= second_d;
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    mul_q <= mul_d;
    hi_q <= hi_d;
    res_q <= (st_q == StTwB && mphase_q) ? res_q : res_d;
  end

  `MT_ASSERT_IMP(a_take_idle, clk_i, rst_ni, cmd_ready_o, st_q == StIdle && !ovalid_q)
  `MT_ASSERT_IMP(a_idx_range, clk_i, rst_ni, 1'b1, idx_q <= IdxW'(MtN))
  `MT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready,
                  out_valid && $stable(value_bits_o))

endmodule
